>>> rtl/core/tpde_pkg.sv
`default_nettype none

package tpde_pkg;

  localparam int COORD_W     = 32;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int DELTA_LIMIT = 127;
  localparam int IMAGE_PAIRS = 4;
  localparam int PAIR_CNT_W  = $clog2(IMAGE_PAIRS + 1);

  localparam logic [BYTE_W-1:0] FULL_FLAG_RST = 8'h80;
  localparam logic [BYTE_W-1:0] END_FLAG_RST  = 8'h7F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_FLAG = 2'd0,
    CFG_END_FLAG  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [BYTE_W-1:0] pair_first;
    logic signed [BYTE_W-1:0] pair_second;
    logic                     run_last;
  } out_beat_t;

  // One classified point waiting to be serialized.
  typedef struct packed {
    logic                escape;
    logic [BYTE_W-1:0]   dx_byte;
    logic [BYTE_W-1:0]   dy_byte;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
  } enc_item_t;

  // Handshake between encode stage and emitter.
  typedef struct packed {
    logic vld;
  } enc_ctl_t;

  // Signed value within +/-DELTA_LIMIT, checked with one add and compare.
  function automatic logic small_delta(input logic [COORD_W-1:0] d);
    logic [COORD_W-1:0] biased;
    biased = d + COORD_W'(DELTA_LIMIT);
    return biased <= COORD_W'(2 * DELTA_LIMIT);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tpde_encode.sv
`default_nettype none

module tpde_encode (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tpde_pkg::in_beat_t            in_beat,
  input  wire logic [tpde_pkg::BYTE_W-1:0]   full_flag,
  input  wire logic [tpde_pkg::BYTE_W-1:0]   end_flag,
  input  wire logic                          take,
  output tpde_pkg::enc_ctl_t                 ctl,
  output tpde_pkg::enc_item_t                item
);
  import tpde_pkg::*;

  logic [COORD_W-1:0] prev_x_r, prev_y_r;
  logic               seen_r;
  logic               enc_vld_r, enc_vld_nxt;
  enc_item_t          enc_r, enc_nxt;
  logic [COORD_W-1:0] dx, dy;
  logic               is_end, is_full, accept;

  assign in_stall = enc_vld_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    dx      = COORD_W'(in_beat.point_x) - prev_x_r;
    dy      = COORD_W'(in_beat.point_y) - prev_y_r;
    is_end  = (dx[BYTE_W-1:0] == end_flag) && (dy[BYTE_W-1:0] == end_flag);
    is_full = (dx[BYTE_W-1:0] == full_flag) && (dy[BYTE_W-1:0] == full_flag);
    enc_nxt.escape  = !seen_r || !small_delta(dx) || !small_delta(dy) || is_end || is_full;
    enc_nxt.dx_byte = dx[BYTE_W-1:0];
    enc_nxt.dy_byte = dy[BYTE_W-1:0];
    enc_nxt.x       = COORD_W'(in_beat.point_x);
    enc_nxt.y       = COORD_W'(in_beat.point_y);
  end

  always_comb begin
    enc_vld_nxt = enc_vld_r;
    if (accept) begin
      enc_vld_nxt = 1'b1;
    end else if (take) begin
      enc_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_vld_r <= 1'b0;
      seen_r    <= 1'b0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else begin
      enc_vld_r <= enc_vld_nxt;
      if (accept) begin
        seen_r   <= 1'b1;
        prev_x_r <= enc_nxt.x;
        prev_y_r <= enc_nxt.y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      enc_r <= enc_nxt;
    end
  end

  assign ctl.vld  = enc_vld_r;
  assign item     = enc_r;

endmodule

`default_nettype wire

>>> rtl/core/tpde_emit.sv
`default_nettype none

module tpde_emit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tpde_pkg::enc_ctl_t            ctl,
  input  wire tpde_pkg::enc_item_t           item,
  input  wire logic [tpde_pkg::BYTE_W-1:0]   full_flag,
  output logic                               take,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tpde_pkg::out_beat_t                out_beat
);
  import tpde_pkg::*;

  logic [PAIR_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  out_vld_r, out_vld_nxt;
  out_beat_t             out_r, out_nxt;
  logic                  load, last;

  assign load = ctl.vld && (!out_vld_r || !out_stall);
  assign last = !item.escape || (cnt_r == PAIR_CNT_W'(IMAGE_PAIRS));
  assign take = load && last;

  // escape run: flag pair, then x lo, x hi, y lo, y hi half-words
  always_comb begin
    out_nxt.run_last = last;
    if (!item.escape) begin
      out_nxt.pair_first  = $signed(item.dx_byte);
      out_nxt.pair_second = $signed(item.dy_byte);
    end else begin
      case (cnt_r)
        PAIR_CNT_W'(1): begin
          out_nxt.pair_first  = $signed(item.x[7:0]);
          out_nxt.pair_second = $signed(item.x[15:8]);
        end
        PAIR_CNT_W'(2): begin
          out_nxt.pair_first  = $signed(item.x[23:16]);
          out_nxt.pair_second = $signed(item.x[31:24]);
        end
        PAIR_CNT_W'(3): begin
          out_nxt.pair_first  = $signed(item.y[7:0]);
          out_nxt.pair_second = $signed(item.y[15:8]);
        end
        PAIR_CNT_W'(4): begin
          out_nxt.pair_first  = $signed(item.y[23:16]);
          out_nxt.pair_second = $signed(item.y[31:24]);
        end
        default: begin
          out_nxt.pair_first  = $signed(full_flag);
          out_nxt.pair_second = $signed(full_flag);
        end
      endcase
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r;
    if (load) begin
      cnt_nxt     = last ? '0 : cnt_r + 1'b1;
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_beat  = out_r;

endmodule

`default_nettype wire

>>> rtl/core/track_point_delta_encoder_unit.sv
`default_nettype none

// Delta encoder for 2-D track points. Each accepted point is classified
// against the previous point (32-bit wrapped subtract, range check,
// flag-pair compare), held in the encode register and then emitted through
// the output register: one beat (dx, dy) for a short delta, five beats (full
// flag pair, then the little-endian bytes of x and y) for the first point or
// an escaped one. run_last marks the final beat of each point. Throughput is
// one beat per cycle on the output port while out_stall is low; a new point
// is taken in the same cycle the last beat of the held one moves to the
// output register. The first beat of a point reaches the output through
// the encode register, then the output register. cfg_ready is always high;
// write the flag registers only while no point is in flight.

module track_point_delta_encoder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire tpde_pkg::in_beat_t              in_beat,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output tpde_pkg::out_beat_t                  out_beat,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tpde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpde_pkg::BYTE_W-1:0]     cfg_data
);
  import tpde_pkg::*;

  logic [BYTE_W-1:0] full_flag_r, end_flag_r;
  enc_ctl_t          ctl;
  enc_item_t         item;
  logic              take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_flag_r <= FULL_FLAG_RST;
      end_flag_r  <= END_FLAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FULL_FLAG: full_flag_r <= cfg_data;
        CFG_END_FLAG:  end_flag_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  tpde_encode u_encode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .full_flag (full_flag_r),
    .end_flag  (end_flag_r),
    .take      (take),
    .ctl       (ctl),
    .item      (item)
  );

  tpde_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .item      (item),
    .full_flag (full_flag_r),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire

>>> rtl/core/tpde_checker.sv
`default_nettype none

module tpde_checker (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_stall,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire tpde_pkg::out_beat_t   out_beat,
  input  wire logic                  cfg_ready
);

  // held output beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("output beat changed while stalled");

  // reset empties both stages
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // an escape run is emitted without gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_beat.run_last |=> out_valid)
    else $error("gap inside a run");

  // input only stalls behind a held point, so a beat is on the output next cycle
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> out_valid)
    else $error("input stalled without a held point");

  // config port never pushes back
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("cfg_ready dropped");

endmodule

bind track_point_delta_encoder_unit tpde_checker u_tpde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

>>> tb/sv/tb_track_point_delta_encoder_unit.sv
`timescale 1ns / 1ps

module tb_track_point_delta_encoder_unit;
  import tpde_pkg::*;

  localparam int RESET_CYCLES     = 7;
  localparam int RANDOM_PER_PHASE = 50;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 4;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int MAX_PRINTS       = 40;
  localparam int NUM_ROWS         = 27;

  // indexes past the two flag registers; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic {ROW_POINT, ROW_CFG} row_op_e;

  typedef struct packed {
    row_op_e              op;
    logic [CFG_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]    data;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic                 typed;
    logic [2:0]           n_pairs;
    logic [BYTE_W-1:0]    first;
    logic [BYTE_W-1:0]    second;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_beat;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_beat;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  track_point_delta_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // encoder state as the testbench tracks it
  logic [COORD_W-1:0] track_x;
  logic [COORD_W-1:0] track_y;
  logic               track_seen;
  logic [BYTE_W-1:0]  full_flag;
  logic [BYTE_W-1:0]  end_flag;
  out_beat_t          pending_pairs[$];

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  bit hold_req       = 1'b0;

  function automatic out_beat_t make_pair(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b,
                                          logic last);
    out_beat_t pr;
    pr.pair_first  = a;
    pr.pair_second = b;
    pr.run_last    = last;
    return pr;
  endfunction

  function automatic void append_pair(out_beat_t pr);
    pending_pairs = {pending_pairs, pr};
  endfunction

  function automatic bit fits_byte_delta(logic [COORD_W-1:0] d);
    int sd;
    sd = d;
    return (sd >= -DELTA_LIMIT) && (sd <= DELTA_LIMIT);
  endfunction

  // Queues the pairs one point produces and advances the tracked state.
  function automatic int encode_point(in_beat_t p, output out_beat_t lead);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] w;
    logic [BYTE_W-1:0]  bx;
    logic [BYTE_W-1:0]  by;
    logic               had;
    dx = p.point_x - track_x;
    dy = p.point_y - track_y;
    bx = dx[BYTE_W-1:0];
    by = dy[BYTE_W-1:0];
    had = track_seen;
    track_x = p.point_x;
    track_y = p.point_y;
    track_seen = 1'b1;
    if (had && fits_byte_delta(dx) && fits_byte_delta(dy) &&
        !(bx == end_flag && by == end_flag) && !(bx == full_flag && by == full_flag)) begin
      lead = make_pair(bx, by, 1'b1);
      append_pair(lead);
      return 1;
    end
    lead = make_pair(full_flag, full_flag, 1'b0);
    append_pair(lead);
    for (int k = 0; k < IMAGE_PAIRS; k++) begin
      w = (k < 2) ? p.point_x : p.point_y;
      w = w >> ((k % 2) * 16);
      append_pair(make_pair(w[7:0], w[15:8], k == IMAGE_PAIRS - 1));
    end
    return IMAGE_PAIRS + 1;
  endfunction

  function automatic in_beat_t pick_point();
    in_beat_t           p;
    int                 r;
    logic [BYTE_W-1:0]  f;
    logic [COORD_W-1:0] corner [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    r = $urandom_range(99);
    if (r < 50) begin
      // mostly short hops, straddling the +/-DELTA_LIMIT edge
      p.point_x = track_x + (int'($urandom_range(260)) - 130);
      p.point_y = track_y + (int'($urandom_range(260)) - 130);
      if (r < 6) p.point_y = $urandom;
    end else if (r < 62) begin
      f = $urandom_range(1) ? full_flag : end_flag;
      p.point_x = track_x + {{24{f[7]}}, f};
      p.point_y = track_y + {{24{f[7]}}, f};
    end else if (r < 72) begin
      p.point_x = corner[$urandom_range(3)];
      p.point_y = corner[$urandom_range(3)];
    end else begin
      p.point_x = $urandom;
      p.point_y = $urandom;
    end
    return p;
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < MAX_PRINTS) $display("ERROR %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic offer_point(in_beat_t p, output int n_pairs, output out_beat_t lead);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_beat  <= p;
    do @(posedge clk); while (in_stall);
    n_pairs = encode_point(p, lead);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_FULL_FLAG) full_flag = val;
    else if (idx == CFG_END_FLAG) end_flag = val;
  endtask

  task automatic drain_pairs();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : pair_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %0d,%0d last %0b",
                                  out_beat.pair_first, out_beat.pair_second,
                                  out_beat.run_last));
      end else begin
        want = pending_pairs.pop_front();
        if (out_beat.pair_first !== want.pair_first)
          report_mismatch($sformatf("pair_first %0d, want %0d",
                                    out_beat.pair_first, want.pair_first));
        if (out_beat.pair_second !== want.pair_second)
          report_mismatch($sformatf("pair_second %0d, want %0d",
                                    out_beat.pair_second, want.pair_second));
        if (out_beat.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %0b, want %0b",
                                    out_beat.run_last, want.run_last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL track_point_delta_encoder_unit");
      $finish;
    end
  end

  // receiver: random stall, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    script_row_t       script [NUM_ROWS];
    logic [BYTE_W-1:0] phase_full [4];
    logic [BYTE_W-1:0] phase_end [4];
    int                phase_idle [4];
    int                phase_stall [4];
    int                n;
    out_beat_t         lead;
    in_beat_t          p;

    // flags start at full = -128, end = 127
    script = '{
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 3'd5, 8'h80, 8'h80},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0005, 32'hFFFF_FFFD, 1'b1, 3'd1, 8'h05, 8'hFD},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0084, 32'hFFFF_FF7E, 1'b1, 3'd1, 8'h7F, 8'h81},
      // dx of -128, then dy of +128
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0004, 32'hFFFF_FF7E, 1'b1, 3'd5, 8'h80, 8'h80},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0004, 32'hFFFF_FFFE, 1'b1, 3'd5, 8'h80, 8'h80},
      // delta lands on the end pair
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0083, 32'h0000_007D, 1'b1, 3'd5, 8'h80, 8'h80},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 3'd5, 8'h80, 8'h80},
      // wrapped deltas across the sign boundary
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 3'd1, 8'h01, 8'hFF},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 3'd1, 8'hFF, 8'h01},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd5, 8'h80, 8'h80},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd1, 8'h00, 8'h00},
      '{ROW_CFG,   CFG_FULL_FLAG, 8'h05, 32'h0,         32'h0,         1'b0, 3'd0, 8'h00, 8'h00},
      // delta lands on the full pair
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0004, 32'h0000_0004, 1'b1, 3'd5, 8'h05, 8'h05},
      '{ROW_CFG,   CFG_END_FLAG,  8'h80, 32'h0,         32'h0,         1'b0, 3'd0, 8'h00, 8'h00},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0003, 32'h0000_0003, 1'b1, 3'd1, 8'hFF, 8'hFF},
      // both flags equal
      '{ROW_CFG,   CFG_FULL_FLAG, 8'h7F, 32'h0,         32'h0,         1'b0, 3'd0, 8'h00, 8'h00},
      '{ROW_CFG,   CFG_END_FLAG,  8'h7F, 32'h0,         32'h0,         1'b0, 3'd0, 8'h00, 8'h00},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0082, 32'h0000_0082, 1'b1, 3'd5, 8'h7F, 8'h7F},
      '{ROW_CFG,   CFG_SPARE_LO,  8'h00, 32'h0,         32'h0,         1'b0, 3'd0, 8'h00, 8'h00},
      '{ROW_CFG,   CFG_SPARE_HI,  8'hFF, 32'h0,         32'h0,         1'b0, 3'd0, 8'h00, 8'h00},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0082, 32'h0000_0082, 1'b1, 3'd1, 8'h00, 8'h00},
      '{ROW_CFG,   CFG_FULL_FLAG, 8'h00, 32'h0,         32'h0,         1'b0, 3'd0, 8'h00, 8'h00},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h0000_0082, 32'h0000_0082, 1'b1, 3'd5, 8'h00, 8'h00},
      '{ROW_CFG,   CFG_FULL_FLAG, 8'h80, 32'h0,         32'h0,         1'b0, 3'd0, 8'h00, 8'h00},
      '{ROW_CFG,   CFG_END_FLAG,  8'h7F, 32'h0,         32'h0,         1'b0, 3'd0, 8'h00, 8'h00},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 3'd0, 8'h00, 8'h00},
      '{ROW_POINT, CFG_FULL_FLAG, 8'h00, 32'h1234_5600, 32'h9ABC_DF6F, 1'b0, 3'd0, 8'h00, 8'h00}
    };

    in_valid   = 1'b0;
    in_beat    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_FULL_FLAG;
    cfg_data   = '0;
    rst_n      = 1'b0;
    track_x    = '0;
    track_y    = '0;
    track_seen = 1'b0;
    full_flag  = FULL_FLAG_RST;
    end_flag   = END_FLAG_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].op == ROW_CFG) begin
        drain_pairs();
        write_reg(script[i].idx, script[i].data);
      end else begin
        p.point_x = script[i].x;
        p.point_y = script[i].y;
        offer_point(p, n, lead);
        if (script[i].typed && (n != script[i].n_pairs ||
            lead.pair_first != script[i].first || lead.pair_second != script[i].second))
          report_mismatch($sformatf("row %0d: %0d beats led by %0d,%0d, table has %0d",
                                    i, n, lead.pair_first, lead.pair_second,
                                    script[i].n_pairs));
      end
    end

    phase_full  = '{FULL_FLAG_RST, 8'($urandom), 8'h7F, 8'h03};
    phase_end   = '{END_FLAG_RST, 8'($urandom), 8'h80, 8'h03};
    phase_idle  = '{0, 77, 0, 13};
    phase_stall = '{0, 0, 77, 13};

    for (int ph = 0; ph < 4; ph++) begin
      drain_pairs();
      write_reg(CFG_FULL_FLAG, phase_full[ph]);
      write_reg(CFG_END_FLAG, phase_end[ph]);
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int j = 0; j < RANDOM_PER_PHASE; j++) begin
        // long output hold-off while points keep coming, so the input backs up
        if (ph == 0 && j == 10) hold_req = 1'b1;
        if (ph == 3 && j == RANDOM_PER_PHASE / 2) drain_pairs();
        offer_point(pick_point(), n, lead);
      end
    end

    drain_pairs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS track_point_delta_encoder_unit");
    end else begin
      $display("FAIL track_point_delta_encoder_unit");
    end
    $finish;
  end

endmodule
